// File: rtl/rhh_pkg.sv
package rhh_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int HASH_W  = 32;
  localparam int CNT_W   = 11;
  localparam int TB_W    = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [TB_W-1:0] TB_RESET = 4'd10;

  // Register index of table_bits (paddr[2])
  localparam logic REG_TABLE_BITS = 1'b0;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_FIND = 2'd1,
    OP_DEL  = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_HIT  = 2'd1,
    STAT_MISS = 2'd2,
    STAT_FULL = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } fsm_e;

  typedef enum logic [1:0] {
    PH_PROBE,
    PH_INSERT,
    PH_SHIFT
  } phase_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  item_key;
    logic [VAL_W-1:0]  item_value;
    logic [HASH_W-1:0] hash_code;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

endpackage

// File: rtl/rhh_mem.sv
module rhh_mem #(
  parameter int AW = 10,
  parameter int DW = 75
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [1<<AW];
  logic [DW-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rhh_apb.sv
module rhh_apb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rhh_pkg::PADDR_W-1:0]  paddr,
  input  logic [rhh_pkg::PDATA_W-1:0]  pwdata,
  output logic [rhh_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [rhh_pkg::TB_W-1:0]     table_bits_o,
  output logic                         clear_o
);
  import rhh_pkg::*;

  logic [TB_W-1:0] tb_q, tb_d;
  logic            wr_hit;

  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TABLE_BITS);

  // Capture table_bits on a write request
  always_comb begin
    tb_d = tb_q;
    if (wr_hit) begin
      tb_d = pwdata[TB_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q <= TB_RESET;
    end else begin
      tb_q <= tb_d;
    end
  end

  // Read back; empty address above the register
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_BITS) begin
      prdata = PDATA_W'(tb_q);
    end
  end

  assign pready       = 1'b1;
  assign table_bits_o = tb_q;
  assign clear_o      = wr_hit;

endmodule

// File: rtl/robin_hood_hash_table.sv
// Robin Hood hash table with backward-shift delete. One request (put, find or
// delete) is worked at a time; the home slot is the top table_bits bits of
// hash_code, with table_bits clamped to 1..MAX_TABLE_BITS. All slots live in
// one single-port-read, single-port-write memory with a registered read, and
// each slot visited takes a read state, then an evaluate and write-back state;
// the result is then issued from a done state. After reset and after every
// table_bits write the block sweeps the whole memory, one slot a cycle, with
// in_ready_o low. A finished result waits in the output register while the
// next request is accepted.
module robin_hood_hash_table #(
  parameter int MAX_TABLE_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rhh_pkg::req_t               in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rhh_pkg::rsp_t               out_rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rhh_pkg::PADDR_W-1:0] paddr,
  input  logic [rhh_pkg::PDATA_W-1:0] pwdata,
  output logic [rhh_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rhh_pkg::*;

  localparam int IW    = MAX_TABLE_BITS;
  localparam int DW    = MAX_TABLE_BITS + 1;
  localparam int DEPTH = 1 << MAX_TABLE_BITS;

  typedef struct packed {
    logic [DW-1:0]    pdist;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } slot_t;

  localparam int EW = $bits(slot_t);

  logic [TB_W-1:0] tb;
  logic            cfg_clr;
  logic [4:0]      bits;
  logic [DW-1:0]   slots;
  logic [IW-1:0]   mask;
  logic [IW-1:0]   home;

  fsm_e             state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [1:0]       op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    hole_q, hole_d;
  logic [DW-1:0]    step_q, step_d;
  logic [DW-1:0]    cd_q, cd_d;
  logic [DW-1:0]    count_q, count_d;
  logic [IW-1:0]    clr_q, clr_d;
  logic [1:0]       stat_q, stat_d;
  logic [VAL_W-1:0] found_q, found_d;
  rsp_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr;
  slot_t            mem_wdata;
  logic [EW-1:0]    mem_rdata;
  slot_t            e;
  logic [IW-1:0]    idx_nx;
  logic             bound;

  rhh_apb u_apb (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .table_bits_o (tb),
    .clear_o      (cfg_clr)
  );

  rhh_mem #(.AW(IW), .DW(EW)) u_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (EW'(mem_wdata)),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // Clamp table_bits and derive table geometry
  always_comb begin
    if (tb == '0) begin
      bits = 5'd1;
    end else if ({1'b0, tb} > 5'(MAX_TABLE_BITS)) begin
      bits = 5'(MAX_TABLE_BITS);
    end else begin
      bits = {1'b0, tb};
    end
  end

  assign slots  = DW'(1) << bits;
  assign mask   = IW'(slots - DW'(1));
  assign home   = IW'(in_req_i.hash_code >> (6'd32 - {1'b0, bits}));
  assign e      = slot_t'(mem_rdata);
  assign idx_nx = (idx_q + IW'(1)) & mask;
  assign bound  = (step_q >= slots);

  // Sequencer: probe, insert with swap, backward shift
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    hole_d      = hole_q;
    step_d      = step_q;
    cd_d        = cd_q;
    count_d     = count_q;
    clr_d       = clr_q;
    stat_d      = stat_q;
    found_d     = found_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + IW'(1);
        if (clr_q == IW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_req_i.opcode;
          key_d   = in_req_i.item_key;
          val_d   = in_req_i.item_value;
          idx_d   = home;
          step_d  = '0;
          phase_d = PH_PROBE;
          found_d = '0;
          if (in_req_i.opcode == OP_NOP) begin
            stat_d  = STAT_MISS;
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        case (phase_q)
          PH_PROBE: begin
            if (op_q == OP_PUT) begin
              if (bound) begin
                stat_d  = STAT_FULL;
                state_d = S_DONE;
              end else if (e.pdist == step_q + DW'(1) && e.key == key_q) begin
                // Update in place
                mem_we    = 1'b1;
                mem_wdata = '{pdist: e.pdist, key: e.key, val: val_q};
                stat_d    = STAT_HIT;
                state_d   = S_DONE;
              end else if (step_q >= e.pdist) begin
                if (count_q >= slots) begin
                  stat_d  = STAT_FULL;
                  state_d = S_DONE;
                end else begin
                  // Reuse the held read data for the first swap
                  phase_d = PH_INSERT;
                  cd_d    = step_q + DW'(1);
                  step_d  = '0;
                end
              end else begin
                step_d  = step_q + DW'(1);
                idx_d   = idx_nx;
                state_d = S_READ;
              end
            end else begin
              if (bound || e.pdist == '0) begin
                stat_d  = STAT_MISS;
                state_d = S_DONE;
              end else if (e.key == key_q) begin
                if (op_q == OP_FIND) begin
                  stat_d  = STAT_HIT;
                  found_d = e.val;
                  state_d = S_DONE;
                end else begin
                  hole_d  = idx_q;
                  idx_d   = idx_nx;
                  step_d  = '0;
                  phase_d = PH_SHIFT;
                  state_d = S_READ;
                end
              end else if (step_q >= e.pdist) begin
                stat_d  = STAT_MISS;
                state_d = S_DONE;
              end else begin
                step_d  = step_q + DW'(1);
                idx_d   = idx_nx;
                state_d = S_READ;
              end
            end
          end
          PH_INSERT: begin
            mem_we    = 1'b1;
            mem_wdata = '{pdist: cd_q, key: key_q, val: val_q};
            if (e.pdist == '0 || bound) begin
              count_d = count_q + DW'(1);
              stat_d  = STAT_OK;
              state_d = S_DONE;
            end else begin
              // Carry the evicted resident onward
              cd_d    = e.pdist + DW'(1);
              key_d   = e.key;
              val_d   = e.val;
              idx_d   = idx_nx;
              step_d  = step_q + DW'(1);
              state_d = S_READ;
            end
          end
          PH_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = hole_q;
            if (!bound && e.pdist > DW'(1)) begin
              mem_wdata = '{pdist: e.pdist - DW'(1), key: e.key, val: e.val};
              hole_d    = idx_q;
              idx_d     = idx_nx;
              step_d    = step_q + DW'(1);
              state_d   = S_READ;
            end else begin
              mem_wdata = '{pdist: '0, key: e.key, val: e.val};
              if (count_q != '0) begin
                count_d = count_q - DW'(1);
              end
              stat_d  = STAT_OK;
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = '{status: stat_q, found_value: found_q,
                          entry_count: CNT_W'(count_q)};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Empty the table on a register write
    if (cfg_clr) begin
      state_d = S_CLEAR;
      clr_d   = '0;
      count_d = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= PH_PROBE;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    val_q   <= val_d;
    idx_q   <= idx_d;
    hole_q  <= hole_d;
    step_q  <= step_d;
    cd_q    <= cd_d;
    stat_q  <= stat_d;
    found_q <= found_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: rtl/rhh_chk.sv
module rhh_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rhh_pkg::rsp_t out_rsp_o,
  input logic          psel,
  input logic          penable,
  input logic          pwrite
);
  import rhh_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  // Found value only on a hit
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != STAT_HIT |-> out_rsp_o.found_value == '0)
    else $error("nonzero found_value without a hit");

  // No result appears in the cycle right after a request
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // A register write starts the clearing sweep
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !in_ready_o)
    else $error("request taken during clearing sweep");

endmodule

bind robin_hood_hash_table rhh_chk u_rhh_chk (.*);

// File: tb/sv/robin_hood_hash_table_checker.sv
module robin_hood_hash_table_checker
  import rhh_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  req_t            in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  rsp_t            out_rsp_i,
  input  logic            cfg_wr_i,
  input  logic [TB_W-1:0] cfg_bits_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int DEPTH = 1024;

  logic [CNT_W-1:0] dist_q [DEPTH];
  logic [KEY_W-1:0] key_q  [DEPTH];
  logic [VAL_W-1:0] val_q  [DEPTH];
  int unsigned      count_q;
  logic [TB_W-1:0]  bits_q;
  rsp_t             expected_rsp_q [$];

  // Empty the table model.
  function automatic void wipe_table();
    for (int i = 0; i < DEPTH; i++) dist_q[i] = '0;
    count_q = 0;
  endfunction

  // Apply one request to the table model and return its response.
  function automatic rsp_t apply_request(req_t rq);
    int unsigned bits, slots, msk, idx, d, e, cd, hole, nxt, td;
    logic [KEY_W-1:0] ck, tk;
    logic [VAL_W-1:0] cv, tv;
    bit stopped, hit;
    rsp_t r;
    bits = (bits_q < 1) ? 1 : (bits_q > 10) ? 10 : bits_q;
    slots = 1 << bits;
    msk = slots - 1;
    idx = rq.hash_code >> (32 - bits);
    r = '0;
    r.status = STAT_MISS;
    stopped = 0;
    hit = 0;
    case (op_e'(rq.opcode))
      OP_PUT: begin
        d = 1;
        for (int s = 0; s < slots; s++) begin
          e = dist_q[idx];
          if (e == d && key_q[idx] == rq.item_key) begin
            val_q[idx] = rq.item_value;
            hit = 1;
            break;
          end
          if (d > e) begin
            stopped = 1;
            break;
          end
          d++;
          idx = (idx + 1) & msk;
        end
        if (hit) r.status = STAT_HIT;
        else if (!stopped || count_q >= slots) r.status = STAT_FULL;
        else begin
          cd = d; ck = rq.item_key; cv = rq.item_value;
          for (int s = 0; s < slots && dist_q[idx] != 0; s++) begin
            td = dist_q[idx]; tk = key_q[idx]; tv = val_q[idx];
            dist_q[idx] = cd; key_q[idx] = ck; val_q[idx] = cv;
            cd = td + 1; ck = tk; cv = tv;
            idx = (idx + 1) & msk;
          end
          dist_q[idx] = cd; key_q[idx] = ck; val_q[idx] = cv;
          count_q++;
          r.status = STAT_OK;
        end
      end
      OP_FIND, OP_DEL: begin
        for (int p = 1; p <= slots; p++) begin
          e = dist_q[idx];
          if (e == 0) break;
          if (key_q[idx] == rq.item_key) begin
            hit = 1;
            break;
          end
          if (p > e) break;
          idx = (idx + 1) & msk;
        end
        if (hit && rq.opcode == OP_FIND) begin
          r.status = STAT_HIT;
          r.found_value = val_q[idx];
        end else if (hit) begin
          hole = idx;
          nxt = (idx + 1) & msk;
          for (int s = 0; s < slots && dist_q[nxt] > 1; s++) begin
            dist_q[hole] = dist_q[nxt] - 1;
            key_q[hole] = key_q[nxt];
            val_q[hole] = val_q[nxt];
            hole = nxt;
            nxt = (nxt + 1) & msk;
          end
          dist_q[hole] = '0;
          if (count_q > 0) count_q--;
          r.status = STAT_OK;
        end
      end
      default: ;
    endcase
    r.entry_count = count_q[CNT_W-1:0];
    return r;
  endfunction

  assign pending_o = expected_rsp_q.size();

  // Track config, predict on accepted requests, compare accepted responses.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    int   errs;
    if (!rst_ni) begin
      bits_q = TB_RESET;
      wipe_table();
      expected_rsp_q.delete();
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (cfg_wr_i) begin
        bits_q = cfg_bits_i;
        wipe_table();
      end
      if (in_valid_i && in_ready_i) expected_rsp_q.push_back(apply_request(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response %p", out_rsp_i);
          errs++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_rsp_i.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp_i.status);
            errs++;
          end
          if (out_rsp_i.found_value !== exp_rsp.found_value) begin
            $error("found_value: expected %0h, got %0h", exp_rsp.found_value,
                   out_rsp_i.found_value);
            errs++;
          end
          if (out_rsp_i.entry_count !== exp_rsp.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_rsp.entry_count,
                   out_rsp_i.entry_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// File: tb/sv/robin_hood_hash_table_tb.sv
module robin_hood_hash_table_tb;
  import rhh_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  req_t               in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  rsp_t               out_rsp_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  logic [KEY_W-1:0]   key_pool [64];
  int unsigned        pool_size = 16;

  robin_hood_hash_table dut (.*);

  robin_hood_hash_table_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o),
    .cfg_wr_i(psel && penable && pwrite && pready && paddr[2] == REG_TABLE_BITS),
    .cfg_bits_i(pwdata[TB_W-1:0]), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // End the run at a generous cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("robin_hood_hash_table: mismatch");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the response side at random.
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= (gap_len() == 0);
  end

  // Valid stays high into the next request when there is no gap.
  task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                              logic [31:0] h);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= {op, k, v, h};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_table_bits(logic [3:0] b);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {28'd0, b};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly keys from a small pool so puts, finds and deletes interact.
  task automatic random_request();
    logic [31:0] k, h;
    logic [1:0]  op;
    int r;
    r = $urandom_range(0, 99);
    op = (r < 45) ? OP_PUT : (r < 70) ? OP_FIND : (r < 95) ? OP_DEL : OP_NOP;
    if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, pool_size - 1)];
    else k = $urandom;
    // Hash from key keeps each key at a fixed home; sometimes use a random one.
    if ($urandom_range(0, 9) < 8) h = k * 32'h9E3779B1;
    else h = $urandom;
    send_request(op, k, $urandom, h);
  endtask

  initial begin
    logic [3:0] phase_bits [6];
    phase_bits = '{4'd1, 4'd2, 4'd0, 4'd15, 4'd4, 4'd10};
    for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two-slot table, fill, update, full, finds, deletes, nop.
    write_table_bits(4'd1);
    send_request(OP_FIND, 32'h0, 32'h0, 32'h0);
    send_request(OP_DEL, 32'h0, 32'h0, 32'h0);
    send_request(OP_PUT, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(OP_PUT, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
    send_request(OP_PUT, 32'h0, 32'h12345678, 32'hFFFFFFFF);
    send_request(OP_PUT, 32'h5A5A5A5A, 32'hA5A5A5A5, 32'h0);
    send_request(OP_FIND, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
    send_request(OP_FIND, 32'h0, 32'h0, 32'hFFFFFFFF);
    send_request(OP_FIND, 32'h13, 32'h0, 32'h0);
    send_request(OP_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(OP_DEL, 32'h0, 32'h0, 32'hFFFFFFFF);
    send_request(OP_FIND, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
    send_request(OP_DEL, 32'h77, 32'h0, 32'h0);
    send_request(OP_DEL, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
    drain();

    // Random phases over several table sizes, extremes included.
    foreach (phase_bits[p]) begin
      write_table_bits(phase_bits[p]);
      pool_size = (phase_bits[p] >= 4 && phase_bits[p] <= 10) ? 64 : 6;
      repeat (250) random_request();
      drain();
    end

    if (fail_count == 0) $display("robin_hood_hash_table: match");
    else $display("robin_hood_hash_table: mismatch");
    $finish;
  end

endmodule
